/* sv/bdeq_pkg.sv */
// bdeq_pkg: shared types and codes for the bounded double-ended queue
// holds the command and result beat structs, opcodes and status codes
// no dependencies
package bdeq_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned WORD_WIDTH_DEF = 64;

	localparam int unsigned OPC_W   = 3;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned OCC_W   = 5;

	// opcodes; codes five to seven are ignored
	localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPC_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPC_W-1:0] OP_REVERSE    = 3'd4;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [OPC_W-1:0]   opcode;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] front_value;
		logic [VALUE_W-1:0] back_value;
		logic               is_empty;
		logic [OCC_W-1:0]   occupancy;
	} res_t;

endpackage

/* sv/bounded_double_ended_queue.sv */
// bounded_double_ended_queue: top level of the bounded double-ended queue
// pointer and direction control, read stage and result register
// depends on bdeq_pkg and bdeq_store
//
// channel  | valid      | ready      | payload             | meaning
// ---------+------------+------------+---------------------+--------------------------
// command  | cmd_valid  | cmd_ready  | cmd (bdeq_pkg::cmd_t)| one operation per beat
// result   | res_valid  | res_ready  | res (bdeq_pkg::res_t)| queue view after the op
//
// one operation accepted per clock while cmd_ready is high; its result beat passes
// through the read stage and then the result register before it reaches the port
// the pointer update and the store write happen at the accepting edge, and the
// front and back words come out of the two registered store read ports
// a stalled result side parks one beat in the result register and one in the
// read stage; cmd_ready drops only when both are full
// reset clears pointers, count, direction and valids; the store needs no clearing
module bounded_double_ended_queue #(
	parameter int unsigned DEPTH      = bdeq_pkg::DEPTH_DEF,
	parameter int unsigned WORD_WIDTH = bdeq_pkg::WORD_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  bdeq_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output bdeq_pkg::res_t  res
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam int unsigned VW = bdeq_pkg::VALUE_W;
	localparam int unsigned OW = bdeq_pkg::OCC_W;

	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

	// ring arithmetic: pos < DEPTH and off <= DEPTH, so one subtract folds the sum
	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] pos,
		input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(pos) + SW'(off);
		if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[IW-1:0];
	endfunction

	function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] pos);
		return (pos == '0) ? LAST_IDX : pos - 1'b1;
	endfunction

	// architectural queue state
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic          rev_q;

	// read stage (store read data lives in bdeq_store)
	logic              valid_s1;
	bdeq_pkg::status_t status_s1;
	logic              rev_s1;
	logic [CW-1:0]     count_s1;

	// result register
	logic           res_valid_q;
	bdeq_pkg::res_t res_q;

	// next state
	logic              cmd_fire;
	logic              res_load;
	logic              full;
	logic              empty;
	logic              at_tail;
	logic [IW-1:0]     head_nxt;
	logic [CW-1:0]     count_nxt;
	logic              rev_nxt;
	logic [IW-1:0]     tail_nxt;
	bdeq_pkg::status_t status_nxt;
	logic              wr_c;
	logic [IW-1:0]     waddr_c;

	logic [WORD_WIDTH-1:0] head_word;
	logic [WORD_WIDTH-1:0] tail_word;
	logic [WORD_WIDTH-1:0] front_word;
	logic [WORD_WIDTH-1:0] back_word;

	// handshakes: the read stage drains into the result register whenever that
	// register is free or being emptied
	assign res_load  = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || res_load;
	assign cmd_fire  = cmd_valid && cmd_ready;

	assign full  = (count_q == DEPTH_C);
	assign empty = (count_q == '0);

	// which physical end the op touches: back ops hit the tail unless reversed
	assign at_tail = ((cmd.opcode == bdeq_pkg::OP_PUSH_BACK) ||
		(cmd.opcode == bdeq_pkg::OP_POP_BACK)) != rev_q;

	always_comb begin
		head_nxt   = head_q;
		count_nxt  = count_q;
		rev_nxt    = rev_q;
		status_nxt = bdeq_pkg::ST_DONE;
		wr_c       = 1'b0;
		waddr_c    = ring_add(head_q, count_q);
		case (cmd.opcode)
			bdeq_pkg::OP_PUSH_BACK, bdeq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_nxt = bdeq_pkg::ST_FULL;
				end else begin
					wr_c      = 1'b1;
					count_nxt = count_q + 1'b1;
					if (!at_tail) begin
						head_nxt = ring_dec(head_q);
						waddr_c  = head_nxt;
					end
				end
			end
			bdeq_pkg::OP_POP_FRONT, bdeq_pkg::OP_POP_BACK: begin
				if (empty) begin
					status_nxt = bdeq_pkg::ST_EMPTY;
				end else begin
					count_nxt = count_q - 1'b1;
					if (!at_tail) begin
						head_nxt = ring_add(head_q, CW'(1));
					end
				end
			end
			bdeq_pkg::OP_REVERSE: begin
				rev_nxt = !rev_q;
			end
			default: begin
				// unused opcodes leave the queue alone
			end
		endcase
		// last occupied slot after the op; meaningless when the queue goes empty
		tail_nxt = (count_nxt == '0) ? head_nxt : ring_add(head_nxt, count_nxt - 1'b1);
	end

	// pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
		end else if (cmd_fire) begin
			head_q  <= head_nxt;
			count_q <= count_nxt;
			rev_q   <= rev_nxt;
		end
	end

	// ring store, read at the new head and tail in the same edge as the write
	bdeq_store #(
		.DEPTH      (DEPTH),
		.WORD_WIDTH (WORD_WIDTH)
	) u_store (
		.clk     (clk),
		.rd_en   (cmd_fire),
		.we      (cmd_fire && wr_c),
		.waddr   (waddr_c),
		.wdata   (cmd.value[WORD_WIDTH-1:0]),
		.raddr_a (head_nxt),
		.raddr_b (tail_nxt),
		.rdata_a (head_word),
		.rdata_b (tail_word)
	);

	// read stage control and side info
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_fire) begin
			valid_s1 <= 1'b1;
		end else if (res_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			status_s1 <= status_nxt;
			rev_s1    <= rev_nxt;
			count_s1  <= count_nxt;
		end
	end

	// logical ends: a reversed queue swaps the physical head and tail
	assign front_word = rev_s1 ? tail_word : head_word;
	assign back_word  = rev_s1 ? head_word : tail_word;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.status      <= status_s1;
			res_q.front_value <= (count_s1 == '0) ? '0 : VW'(front_word);
			res_q.back_value  <= (count_s1 == '0) ? '0 : VW'(back_word);
			res_q.is_empty    <= (count_s1 == '0);
			res_q.occupancy   <= OW'(count_s1);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	// the count never runs past the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count above depth");

	// a push into a full queue is flagged and leaves the count alone
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && full && ((cmd.opcode == bdeq_pkg::OP_PUSH_BACK) ||
		(cmd.opcode == bdeq_pkg::OP_PUSH_FRONT))
		|=> status_s1 == bdeq_pkg::ST_FULL && count_q == $past(count_q))
		else $error("push on full queue not dropped");

	// a pop from an empty queue is flagged and changes nothing
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && empty && ((cmd.opcode == bdeq_pkg::OP_POP_FRONT) ||
		(cmd.opcode == bdeq_pkg::OP_POP_BACK))
		|=> status_s1 == bdeq_pkg::ST_EMPTY && count_q == '0 && head_q == $past(head_q))
		else $error("pop on empty queue not flagged");

	// a beat parked in the read stage is not lost while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !res_load |=> valid_s1 && $stable(count_s1) && $stable(status_s1))
		else $error("read stage beat dropped during stall");

	// an empty view shows zero words
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.is_empty |-> res_q.front_value == '0 && res_q.back_value == '0)
		else $error("empty result carries data");
`endif

endmodule

/* sv/bdeq_store.sv */
// bdeq_store: ring store of the queue, one write port and two read ports
// read data is registered, a write in the same cycle is forwarded to a matching read
// depends on nothing but its parameters
module bdeq_store #(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned WORD_WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WORD_WIDTH-1:0]    wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WORD_WIDTH-1:0]    rdata_a,
	output logic [WORD_WIDTH-1:0]    rdata_b
);

	logic [WORD_WIDTH-1:0] mem [DEPTH];
	logic [WORD_WIDTH-1:0] rdata_a_q;
	logic [WORD_WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_a_q <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
			rdata_b_q <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* sim/tb.sv */
// tb: self-checking testbench for bounded_double_ended_queue
// drives command beats, predicts each result beat and compares it field by field
// depends on bdeq_pkg and the bounded_double_ended_queue RTL
module tb;
	import bdeq_pkg::*;

	localparam int unsigned DEPTH       = DEPTH_DEF;
	localparam int unsigned AW          = $clog2(DEPTH);
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned QUIET_LIMIT = 5000;
	localparam int unsigned SETTLE      = 8;

	// opcodes the block must ignore
	localparam logic [OPC_W-1:0] OP_FIRST_UNUSED = OP_REVERSE + 3'd1;
	localparam logic [OPC_W-1:0] OP_LAST_UNUSED  = '1;

	logic clk;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic res_ready = 1'b0;
	cmd_t cmd       = '0;
	logic cmd_ready;
	logic res_valid;
	res_t res;

	bounded_double_ended_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow of the queue: ring of words, head slot, entry count, direction
	logic [VALUE_W-1:0] ring [DEPTH];
	logic [AW-1:0]      head = '0;
	logic [OCC_W-1:0]   count = '0;
	logic               rev = 1'b0;

	// predicted result beats, oldest first
	res_t pending [$];

	int unsigned fail_count  = 0;
	int unsigned quiet_cycles = 0;

	// receiver knobs, set by the tests and read by the receiver process
	int unsigned ready_pct   = 100;
	int unsigned hold_reqs   = 0;
	int unsigned holds_taken = 0;
	int unsigned hold_left   = 0;
	int unsigned run_left    = 0;
	logic        run_ready   = 1'b1;

	// apply one operation to the shadow queue and return the beat it should produce
	function automatic res_t apply_op(cmd_t c);
		res_t        r;
		logic        at_tail;
		logic [VALUE_W-1:0] h, t;
		r = '0;
		r.status = ST_DONE;
		case (c.opcode)
			OP_PUSH_BACK, OP_PUSH_FRONT: begin
				if (count == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// in reversed view the logical back sits at the physical head
					at_tail = (c.opcode == OP_PUSH_BACK) != rev;
					if (at_tail) begin
						ring[AW'(head + count)] = c.value;
					end else begin
						head = head - 1'b1;
						ring[head] = c.value;
					end
					count = count + 1'b1;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					at_tail = (c.opcode == OP_POP_BACK) != rev;
					if (!at_tail)
						head = head + 1'b1;
					count = count - 1'b1;
				end
			end
			OP_REVERSE: rev = !rev;
			default: ;
		endcase
		if (count != 0) begin
			h = ring[head];
			t = ring[AW'(head + count - 1'b1)];
			r.front_value = rev ? t : h;
			r.back_value  = rev ? h : t;
		end
		r.is_empty  = (count == 0);
		r.occupancy = count;
		return r;
	endfunction

	function automatic logic [VALUE_W-1:0] random_word();
		logic [VALUE_W-1:0] onehot;
		onehot = {{(VALUE_W-1){1'b0}}, 1'b1} << $urandom_range(0, VALUE_W-1);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return onehot;
			3: return ~onehot;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// push_pct biases pushes against pops so the queue swings between full and empty
	function automatic cmd_t random_op(int unsigned push_pct);
		cmd_t        c;
		int unsigned r;
		c.value = random_word();
		r = $urandom_range(0, 99);
		if (r < 3)
			c.opcode = OPC_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
		else if (r < 11)
			c.opcode = OP_REVERSE;
		else if ($urandom_range(0, 99) < push_pct)
			c.opcode = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		else
			c.opcode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
		return c;
	endfunction

	// offer one command beat and hold it until accepted; valid stays high afterwards
	task automatic send_op(input cmd_t c);
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		pending.push_back(apply_op(c));
	endtask

	task automatic send_fields(input logic [OPC_W-1:0] opc, input logic [VALUE_W-1:0] val);
		cmd_t c;
		c.opcode = opc;
		c.value  = val;
		send_op(c);
	endtask

	task automatic idle_sender(input int unsigned cycles);
		if (cycles == 0)
			return;
		cmd_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// sender pauses until every predicted beat has come back
	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result(input res_t got);
		res_t want;
		if (pending.size() == 0) begin
			$error("result beat with no operation outstanding");
			fail_count++;
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			fail_count++;
		end
		if (got.front_value !== want.front_value) begin
			$error("front_value: expected %h, got %h", want.front_value, got.front_value);
			fail_count++;
		end
		if (got.back_value !== want.back_value) begin
			$error("back_value: expected %h, got %h", want.back_value, got.back_value);
			fail_count++;
		end
		if (got.is_empty !== want.is_empty) begin
			$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
			fail_count++;
		end
		if (got.occupancy !== want.occupancy) begin
			$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
			fail_count++;
		end
	endtask

	// receiver: checks accepted beats, then picks ready for the next edge
	// ready runs in random-length stretches; a hold request forces a long stall
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			check_result(res);
		if (hold_reqs != holds_taken && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			holds_taken++;
		end
		if (hold_left != 0) begin
			res_ready <= 1'b0;
			hold_left--;
		end else begin
			if (run_left == 0) begin
				run_ready = ($urandom_range(0, 99) < ready_pct);
				run_left  = $urandom_range(1, 12);
			end
			run_left--;
			res_ready <= run_ready;
		end
	end

	// watchdog: too long without any beat on either channel means a hang
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// empty-queue pops, reverse on empty, ignored codes, filling with both pushes,
	// pushes on a full queue, reverse when full and pops from both ends
	task automatic test_corner_cases();
		ready_pct = 100;
		send_fields(OP_POP_FRONT, '1);
		send_fields(OP_POP_BACK, '0);
		send_fields(OP_REVERSE, '1);
		send_fields(OP_FIRST_UNUSED, '1);
		send_fields(OP_FIRST_UNUSED + 3'd1, '0);
		send_fields(OP_LAST_UNUSED, '1);
		for (int i = 0; i < DEPTH; i++) begin
			logic [VALUE_W-1:0] w;
			case (i)
				0: w = '0;
				1: w = '1;
				2: w = {(VALUE_W/2){2'b01}};
				3: w = {(VALUE_W/2){2'b10}};
				4: w = {{(VALUE_W-1){1'b0}}, 1'b1};
				5: w = {1'b1, {(VALUE_W-1){1'b0}}};
				default: w = random_word();
			endcase
			send_fields(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, w);
		end
		send_fields(OP_PUSH_BACK, '1);
		send_fields(OP_PUSH_FRONT, '1);
		send_fields(OP_REVERSE, '0);
		send_fields(OP_POP_FRONT, '0);
		send_fields(OP_POP_BACK, '0);
		wait_drained();
	endtask

	// bursty traffic in segments; each segment picks its own bias, stall rate and gaps
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned push_pct;
		int unsigned gap_max;
		int unsigned burst_left;
		push_pct   = 50;
		gap_max    = 0;
		burst_left = 0;
		for (int unsigned n = 0; n < n_items; n++) begin
			if (n % 50 == 0) begin
				case ($urandom_range(0, 3))
					0: push_pct = 80;
					1: push_pct = 20;
					default: push_pct = 50;
				endcase
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 80;
					2: ready_pct = 50;
					default: ready_pct = 25;
				endcase
				gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (burst_left == 0) begin
				if (gap_max != 0)
					idle_sender($urandom_range(0, gap_max));
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
			send_op(random_op(push_pct));
		end
		wait_drained();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering beats
	task automatic test_backpressure();
		ready_pct = 100;
		hold_reqs++;
		for (int i = 0; i < 60; i++)
			send_op(random_op(60));
		wait_drained();
	endtask

	// back-to-back beats with the receiver always ready
	task automatic test_streaming(input int unsigned n_items);
		ready_pct = 100;
		for (int unsigned n = 0; n < n_items; n++)
			send_op(random_op((n / 40) % 2 ? 30 : 70));
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_random_traffic(1500);
		test_backpressure();
		test_streaming(360);

		// let any stray beat show up before the verdict
		ready_pct = 100;
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
